[hw/rtl/mafd_pkg.sv]
// shared types and constants of the acceleration/deceleration filter
// no dependencies; imported by the divider, the top level and the bench
package mafd_pkg;

   localparam int MA_DEPTH   = 256;
   localparam int PTR_W      = $clog2(MA_DEPTH);
   localparam int LEN_W      = $clog2(MA_DEPTH + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_MA   = 2'd1;
   localparam logic [1:0] MODE_EXP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_EXP_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXP_BIAS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAC_SHIFT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MA_TAPS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_LOG2 = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MODE,
      S_MA0,
      S_MA1,
      S_MADIV,
      S_INTERP,
      S_EXP1,
      S_EXP2,
      S_EXP3,
      S_EXP4,
      S_OUT
   } mafd_state_type;

endpackage

[hw/rtl/mafd_req_if.sv]
// input channel of the filter: increment, filter select and done flag
// depends on nothing
interface mafd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] move_in;
   logic [1:0]         filter_select;
   logic               done_in;

   modport source (output valid, output move_in, output filter_select, output done_in,
                   input ready);
   modport sink (input valid, input move_in, input filter_select, input done_in,
                 output ready);
endinterface

[hw/rtl/mafd_rsp_if.sv]
// result channel of the filter: filtered increment and done flag
// depends on nothing
interface mafd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] move_out;
   logic               done_out;

   modport source (output valid, output move_out, output done_out, input ready);
   modport sink (input valid, input move_out, input done_out, output ready);
endinterface

[hw/rtl/motion_accel_decel_filter.sv]
// motion acceleration/deceleration filter: moving-average with interpolating smoother,
// exponential filter with bias, or pass-through, on one signed increment per transaction.
// a moving-average ring update waits on the 32-step divider; a stalled result register
// holds the sequencer in its output state. ready only when idle, so a new increment is
// taken only after the last result is loaded. reset clears the sequencer, the settings
// and the filter accumulators, but not the ring memory.
// depends on mafd_pkg, mafd_req_if, mafd_rsp_if, mafd_div
module motion_accel_decel_filter (
   input  logic                                clock,
   input  logic                                reset,
   mafd_req_if.sink                            req_chan,
   mafd_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [mafd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mafd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mafd_pkg::*;

   mafd_state_type     state_ff, state_in;
   logic [31:0]        v_ff, v_in;
   logic               done_ff, done_in;
   logic               cmp_ff, cmp_in;
   logic               via_ff, via_in;

   logic [15:0]        cgain_ff;
   logic [30:0]        cbias_ff;
   logic [4:0]         cshift_ff;
   logic [8:0]         ctaps_ff;
   logic [2:0]         clog_ff;

   logic [1:0]         mode_ff, mode_in;
   logic               empty_ff, empty_in;
   logic [15:0]        hgain_ff, hgain_in;
   logic [30:0]        hbias_ff, hbias_in;
   logic [11:0]        hma_ff, hma_in;
   logic               adopted_ff, adopted_in;

   logic [31:0]        eacc_ff, eacc_in;
   logic [15:0]        efrac_ff, efrac_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        t_ff, t_in;

   logic [31:0]        ma_sum_ff, ma_sum_in;
   logic [31:0]        ma_rem_ff, ma_rem_in;
   logic [PTR_W-1:0]   ma_ptr_ff, ma_ptr_in;
   logic [LEN_W-1:0]   ma_filled_ff, ma_filled_in;
   logic [31:0]        bsum_ff, bsum_in;
   logic [31:0]        last_ff, last_in;
   logic [31:0]        delta_ff, delta_in;
   logic [31:0]        dacc_ff, dacc_in;
   logic [31:0]        irem_ff, irem_in;
   logic [7:0]         bcnt_ff, bcnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_move_ff, rsp_move_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [31:0]        ring_mem [MA_DEPTH];
   logic [31:0]        ring_rd_ff;
   logic               ring_we;

   logic               div_start;
   logic [31:0]        div_dividend;
   logic               div_done;
   logic [31:0]        div_quo;
   logic [31:0]        div_rem;

   logic [LEN_W-1:0]   ma_len;
   logic [47:0]        prod;

   assign ma_len = (hma_ff[11:3] > 9'(MA_DEPTH)) ? LEN_W'(MA_DEPTH) : LEN_W'(hma_ff[11:3]);
   assign prod   = t_ff * hgain_ff;

   mafd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (ma_len),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      logic [1:0]       mode_t;
      logic [11:0]      ms;
      logic             do_clear;
      logic [31:0]      q;
      logic             fin;
      logic [31:0]      old;
      logic [LEN_W:0]   ptr_n;
      logic [31:0]      sum_n;
      logic [31:0]      da;
      logic [31:0]      sumx;
      logic [31:0]      ir;
      logic [3:0]       sh;
      logic [31:0]      acc;
      logic [31:0]      vv;
      logic [31:0]      ea;
      logic [15:0]      ef;
      logic [15:0]      mask16;
      logic [8:0]       cnt;
      logic [7:0]       bc;
      logic [31:0]      bs;

      state_in     = state_ff;
      v_in         = v_ff;
      done_in      = done_ff;
      cmp_in       = cmp_ff;
      via_in       = via_ff;
      mode_in      = mode_ff;
      empty_in     = empty_ff;
      hgain_in     = hgain_ff;
      hbias_in     = hbias_ff;
      hma_in       = hma_ff;
      adopted_in   = adopted_ff;
      eacc_in      = eacc_ff;
      efrac_in     = efrac_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      ma_sum_in    = ma_sum_ff;
      ma_rem_in    = ma_rem_ff;
      ma_ptr_in    = ma_ptr_ff;
      ma_filled_in = ma_filled_ff;
      bsum_in      = bsum_ff;
      last_in      = last_ff;
      delta_in     = delta_ff;
      dacc_in      = dacc_ff;
      irem_in      = irem_ff;
      bcnt_in      = bcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_move_in  = rsp_move_ff;
      rsp_done_in  = rsp_done_ff;
      ring_we      = 1'b0;
      div_start    = 1'b0;
      div_dividend = ma_sum_ff + ma_rem_ff;
      req_chan.ready = (state_ff == S_IDLE);

      mode_t   = mode_ff;
      ms       = {ctaps_ff, clog_ff};
      do_clear = 1'b0;
      q        = v_ff;
      fin      = 1'b0;
      old      = 32'd0;
      ptr_n    = {1'b0, ma_ptr_ff} + 1'b1;
      sum_n    = ma_sum_ff;
      sh       = {hma_ff[2:0], 1'b0};
      da       = dacc_ff + delta_ff;
      sumx     = da + irem_ff;
      ir       = sumx & ~(32'hFFFF_FFFF << sh);
      acc      = eacc_ff + v_ff;
      mask16   = (cshift_ff >= 5'd16) ? 16'hFFFF : 16'((32'd1 << cshift_ff) - 32'd1);
      ef       = t_ff[15:0] & mask16;
      vv       = acc_ff[31] ? (32'($signed(~t_ff) >>> cshift_ff) + 32'd1)
                            : 32'($signed(t_ff) >>> cshift_ff);
      ea       = acc_ff - vv;
      cnt      = 9'd1 << hma_ff[2:0];
      bc       = bcnt_ff + 8'd1;
      bs       = bsum_ff + v_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               v_in    = req_chan.move_in;
               done_in = req_chan.done_in;
               if (empty_ff) begin
                  // settings and mode are adopted only between moves
                  if (hma_ff != ms) begin
                     mode_t     = MODE_NONE;
                     hma_in     = ms;
                     adopted_in = 1'b1;
                  end
                  if (hgain_ff != cgain_ff) begin
                     mode_t   = MODE_NONE;
                     hgain_in = cgain_ff;
                  end
                  hbias_in = cbias_ff;
                  do_clear = (mode_t != req_chan.filter_select);
                  mode_in  = req_chan.filter_select;
               end
               state_in = S_MODE;
            end
         end
         S_MODE: begin
            case (mode_ff)
               MODE_MA: begin
                  if (adopted_ff) begin
                     bsum_in = bs;
                     bcnt_in = bc;
                     if ({1'b0, bc} >= cnt) begin
                        v_in     = bs;
                        via_in   = 1'b1;
                        state_in = S_MA0;
                     end else begin
                        cmp_in   = (ma_sum_ff | ma_rem_ff) == 32'd0;
                        state_in = S_INTERP;
                     end
                  end else begin
                     via_in   = 1'b0;
                     bsum_in  = '0;
                     last_in  = '0;
                     delta_in = '0;
                     dacc_in  = '0;
                     irem_in  = '0;
                     bcnt_in  = '0;
                     state_in = S_MA0;
                  end
               end
               MODE_EXP: begin
                  if (hgain_ff != 16'd0) begin
                     state_in = S_EXP1;
                  end else begin
                     eacc_in  = '0;
                     efrac_in = '0;
                     cmp_in   = 1'b1;
                     state_in = S_OUT;
                  end
               end
               default: begin
                  do_clear = 1'b1;
                  cmp_in   = 1'b1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_MA0: begin
            if (ma_len == '0) begin
               ma_sum_in    = '0;
               ma_rem_in    = '0;
               ma_ptr_in    = '0;
               ma_filled_in = '0;
               cmp_in       = 1'b1;
               q            = v_ff;
               fin          = 1'b1;
            end else begin
               // ring read returns the old entry while the new one is written
               ring_we  = 1'b1;
               state_in = S_MA1;
            end
         end
         S_MA1: begin
            if (ma_filled_ff == ma_len) begin
               old = ring_rd_ff;
            end else begin
               ma_filled_in = '0;
            end
            if (ptr_n >= {1'b0, ma_len}) begin
               ma_ptr_in    = '0;
               ma_filled_in = ma_len;
            end else begin
               ma_ptr_in = PTR_W'(ptr_n);
            end
            sum_n        = ma_sum_ff + v_ff - old;
            ma_sum_in    = sum_n;
            div_start    = 1'b1;
            div_dividend = sum_n + ma_rem_ff;
            state_in     = S_MADIV;
         end
         S_MADIV: begin
            if (div_done) begin
               ma_rem_in = div_rem;
               cmp_in    = (ma_sum_ff | div_rem) == 32'd0;
               q         = div_quo;
               fin       = 1'b1;
            end
         end
         S_INTERP: begin
            dacc_in  = da;
            irem_in  = ir;
            v_in     = 32'($signed(sumx) >>> sh);
            cmp_in   = cmp_ff && ((da | ir) == 32'd0);
            state_in = S_OUT;
         end
         S_EXP1: begin
            acc_in   = acc;
            t_in     = (acc[31] ? (32'd0 - acc) : acc) - {1'b0, hbias_ff};
            state_in = S_EXP2;
         end
         S_EXP2: begin
            if (t_ff != 32'd0 && !t_ff[31]) begin
               t_in     = prod[31:0];
               state_in = S_EXP3;
            end else begin
               // at or below the bias the accumulated input passes through
               v_in     = acc_ff;
               eacc_in  = '0;
               efrac_in = '0;
               cmp_in   = 1'b1;
               state_in = S_OUT;
            end
         end
         S_EXP3: begin
            t_in     = t_ff + ({1'b0, hbias_ff} << cshift_ff) + {16'd0, efrac_ff};
            state_in = S_EXP4;
         end
         S_EXP4: begin
            efrac_in = ef;
            v_in     = vv;
            eacc_in  = ea;
            cmp_in   = (ea | {16'd0, ef}) == 32'd0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_move_in  = v_ff;
               rsp_done_in  = done_ff && cmp_ff;
               empty_in     = done_ff && cmp_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of the moving-average step: feed the smoother or hand out the result
      if (fin) begin
         if (via_ff) begin
            delta_in = q - last_ff;
            last_in  = q;
            bsum_in  = '0;
            bcnt_in  = '0;
            state_in = S_INTERP;
         end else begin
            v_in     = q;
            state_in = S_OUT;
         end
      end

      if (do_clear) begin
         eacc_in      = '0;
         efrac_in     = '0;
         ma_sum_in    = '0;
         ma_rem_in    = '0;
         ma_ptr_in    = '0;
         ma_filled_in = '0;
         bsum_in      = '0;
         last_in      = '0;
         delta_in     = '0;
         dacc_in      = '0;
         irem_in      = '0;
         bcnt_in      = '0;
         empty_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cgain_ff     <= '0;
         cbias_ff     <= '0;
         cshift_ff    <= '0;
         ctaps_ff     <= '0;
         clog_ff      <= '0;
         mode_ff      <= MODE_NONE;
         empty_ff     <= 1'b1;
         hgain_ff     <= '0;
         hbias_ff     <= '0;
         hma_ff       <= '0;
         adopted_ff   <= 1'b0;
         eacc_ff      <= '0;
         efrac_ff     <= '0;
         ma_sum_ff    <= '0;
         ma_rem_ff    <= '0;
         ma_ptr_ff    <= '0;
         ma_filled_ff <= '0;
         bsum_ff      <= '0;
         last_ff      <= '0;
         delta_ff     <= '0;
         dacc_ff      <= '0;
         irem_ff      <= '0;
         bcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_EXP_GAIN:    cgain_ff  <= csr_wdata[15:0];
               REG_EXP_BIAS:    cbias_ff  <= csr_wdata;
               REG_FRAC_SHIFT:  cshift_ff <= csr_wdata[4:0];
               REG_MA_TAPS:     ctaps_ff  <= csr_wdata[8:0];
               REG_INTERP_LOG2: clog_ff   <= csr_wdata[2:0];
               default: ;
            endcase
         end
         mode_ff      <= mode_in;
         empty_ff     <= empty_in;
         hgain_ff     <= hgain_in;
         hbias_ff     <= hbias_in;
         hma_ff       <= hma_in;
         adopted_ff   <= adopted_in;
         eacc_ff      <= eacc_in;
         efrac_ff     <= efrac_in;
         ma_sum_ff    <= ma_sum_in;
         ma_rem_ff    <= ma_rem_in;
         ma_ptr_ff    <= ma_ptr_in;
         ma_filled_ff <= ma_filled_in;
         bsum_ff      <= bsum_in;
         last_ff      <= last_in;
         delta_ff     <= delta_in;
         dacc_ff      <= dacc_in;
         irem_ff      <= irem_in;
         bcnt_ff      <= bcnt_in;
      end
      v_ff        <= v_in;
      done_ff     <= done_in;
      cmp_ff      <= cmp_in;
      via_ff      <= via_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      rsp_move_ff <= rsp_move_in;
      rsp_done_ff <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      ring_rd_ff <= ring_mem[ma_ptr_ff];
      if (ring_we) begin
         ring_mem[ma_ptr_ff] <= v_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.move_out = rsp_move_ff;
   assign rsp_chan.done_out = rsp_done_ff;

   // a newly adopted length clears the fill count by the time the sequencer is idle again
   a_filled: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ma_filled_ff == '0 || ma_filled_ff == ma_len)
      else $error("ring fill count out of step with average length");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_MADIV)
      else $error("divider finished outside the divide wait");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside the output state");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && ma_len != '0 |-> {1'b0, ma_ptr_ff} < ma_len)
      else $error("ring pointer beyond average length");

endmodule

[hw/rtl/mafd_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on mafd_pkg
module mafd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  dividend,
   input  logic [mafd_pkg::LEN_W-1:0]   divisor,
   output logic                         done,
   output logic [31:0]                  quotient,
   output logic [31:0]                  remainder
);
   import mafd_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [31:0]         a_ff, a_in;
   logic [LEN_W-1:0]    r_ff, r_in;
   logic [LEN_W-1:0]    div_ff, div_in;

   always_comb begin
      logic [LEN_W:0] r2;
      logic           ge;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      div_in  = div_ff;
      r2      = {r_ff, a_ff[31]};
      ge      = r2 >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[31];
         a_in    = dividend[31] ? (32'd0 - dividend) : dividend;
         r_in    = '0;
         cnt_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         r_in   = ge ? LEN_W'(r2 - {1'b0, div_ff}) : LEN_W'(r2);
         a_in   = {a_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      a_ff   <= a_in;
      r_ff   <= r_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_ff ? (32'd0 - a_ff) : a_ff;
   assign remainder = neg_ff ? (32'd0 - 32'(r_ff)) : 32'(r_ff);

   a_start_idle: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   a_start_div: assert property (@(posedge clock) disable iff (reset) start |-> divisor != '0)
      else $error("divider started with zero divisor");
   a_rem_lt: assert property (@(posedge clock) disable iff (reset) done_ff |-> r_ff < div_ff)
      else $error("divider remainder not below divisor");

endmodule

[bench/tb_top.sv]
// self-checking bench for motion_accel_decel_filter: directed table, then random phases
// depends on mafd_pkg, mafd_req_if, mafd_rsp_if and the filter top level
module tb_top;
   import mafd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1420;

   typedef struct {
      logic [31:0] move;
      bit          done;
   } move_result_type;

   typedef struct {
      bit                     is_reg;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic [31:0]            move;
      logic [1:0]             sel;
      bit                     done;
      bit                     typed;
      logic [31:0]            exp_move;
      bit                     exp_done;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mafd_req_if req_ch ();
   mafd_rsp_if rsp_ch ();

   motion_accel_decel_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_ch.sink),
      .rsp_chan  (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   move_result_type pending_moves[$];
   stim_row_type    stim_table[$];
   int  error_count;
   int  sent_count;
   int  checked_count;
   int  phase_count;
   int  idle_cycles;
   bit  no_idle;

   // shadow copy of the filter: settings, held settings and state
   logic [31:0] cfg_gain, cfg_bias, cfg_frac, cfg_taps, cfg_lg;
   logic [1:0]  act_mode;
   bit          empty_flag;
   logic [31:0] held_gain, held_bias, held_ma;
   bit          ma_adopted;
   logic [31:0] exp_acc, exp_frac;
   logic [31:0] ring_mem [MA_DEPTH];
   logic [31:0] ma_sum, ma_rem, ma_ptr, ma_fill;
   logic [31:0] blk_sum, last_blk, blk_delta, delta_acc, interp_rem, blk_cnt;
   logic [31:0] work_val;

   function automatic logic [31:0] shr_arith(logic [31:0] v, logic [31:0] s);
      return $signed(v) >>> s[4:0];
   endfunction

   task automatic clear_filter_state();
      exp_acc = 0; exp_frac = 0;
      ma_sum = 0; ma_rem = 0; ma_ptr = 0; ma_fill = 0;
      blk_sum = 0; last_blk = 0; blk_delta = 0; delta_acc = 0;
      interp_rem = 0; blk_cnt = 0;
      empty_flag = 1'b1;
   endtask

   task automatic exp_stage(output bit empty);
      logic [31:0] s, acc, mag, t;
      if (held_gain != 0) begin
         s   = cfg_frac & 32'd31;
         acc = exp_acc + work_val;
         mag = acc[31] ? (32'd0 - acc) : acc;
         t   = mag - held_bias;
         if (t != 0 && !t[31]) begin
            t = t * held_gain;
            t = t + (held_bias << s) + exp_frac;
            exp_frac = (t & 32'hFFFF) & ((32'd1 << s) - 32'd1);
            work_val = acc[31] ? shr_arith(~t, s) + 32'd1 : shr_arith(t, s);
         end else begin
            work_val = acc;
            exp_frac = 0;
         end
         exp_acc = acc - work_val;
      end else begin
         exp_acc  = 0;
         exp_frac = 0;
      end
      empty = (exp_acc | exp_frac) == 0;
   endtask

   task automatic avg_stage(inout logic [31:0] v, output bit empty);
      logic [31:0] len, slot, old, d;
      int di, li, qi;
      len = held_ma >> 3;
      if (len > MA_DEPTH) len = MA_DEPTH;
      if (len != 0) begin
         slot = ma_ptr % MA_DEPTH;
         old  = ring_mem[slot];
         ring_mem[slot] = v;
         if (ma_fill != len) begin
            ma_fill = 0;
            old     = 0;
         end
         ma_ptr = ma_ptr + 1;
         if (ma_ptr >= len) begin
            ma_ptr  = 0;
            ma_fill = len;
         end
         ma_sum = ma_sum + v - old;
         d  = ma_sum + ma_rem;
         di = d;
         li = len;
         qi = di / li;
         v  = qi;
         ma_rem = d - v * len;
      end else begin
         ma_sum = 0; ma_rem = 0; ma_ptr = 0; ma_fill = 0;
      end
      empty = (ma_sum | ma_rem) == 0;
   endtask

   task automatic smooth_stage(output bit empty);
      logic [31:0] lg, cnt, sh, sumx, o;
      bit e;
      lg = held_ma & 32'd7;
      if (ma_adopted) begin
         cnt = 32'd1 << lg;
         sh  = lg << 1;
         blk_sum = blk_sum + work_val;
         blk_cnt = (blk_cnt + 1) & 32'hFF;
         if (blk_cnt >= cnt) begin
            avg_stage(blk_sum, e);
            blk_delta = blk_sum - last_blk;
            last_blk  = blk_sum;
            blk_sum   = 0;
            blk_cnt   = 0;
         end else begin
            e = (ma_sum | ma_rem) == 0;
         end
         delta_acc  = delta_acc + blk_delta;
         sumx       = delta_acc + interp_rem;
         o          = shr_arith(sumx, sh);
         work_val   = o;
         interp_rem = sumx - (o << sh);
         empty = e && ((delta_acc | interp_rem) == 0);
      end else begin
         avg_stage(work_val, e);
         blk_sum = 0; last_blk = 0; blk_delta = 0;
         delta_acc = 0; interp_rem = 0; blk_cnt = 0;
         empty = e;
      end
   endtask

   task automatic predict_move(input logic [31:0] mv, input logic [1:0] sel, input bit dn,
                               output move_result_type res);
      logic [31:0] ms;
      bit e;
      work_val = mv;
      e = 1'b1;
      if (empty_flag) begin
         ms = (cfg_taps << 3) | cfg_lg;
         if (held_ma != ms) begin
            act_mode   = MODE_NONE;
            held_ma    = ms;
            ma_adopted = 1'b1;
         end
         if (held_gain != cfg_gain) begin
            act_mode  = MODE_NONE;
            held_gain = cfg_gain;
         end
         held_bias = cfg_bias;
         if (act_mode != sel) clear_filter_state();
         act_mode = sel;
      end
      if (act_mode == MODE_MA) smooth_stage(e);
      else if (act_mode == MODE_EXP) exp_stage(e);
      else clear_filter_state();
      empty_flag = dn && e;
      res.move = work_val;
      res.done = empty_flag;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, checked_count, got, want);
   endtask

   // ---------------- sender ----------------
   task automatic send_move(input logic [31:0] mv, input logic [1:0] sel, input bit dn,
                            input bit typed, input move_result_type typed_res);
      move_result_type res;
      while (!no_idle && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.move_in       <= mv;
      req_ch.filter_select <= sel;
      req_ch.done_in       <= dn;
      do @(posedge clock); while (!req_ch.ready);
      predict_move(mv, sel, dn, res);
      pending_moves.push_back(typed ? typed_res : res);
      sent_count++;
   endtask

   // registers change only with the filter drained and idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      req_ch.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      case (idx)
         REG_EXP_GAIN:    cfg_gain = data & 32'hFFFF;
         REG_EXP_BIAS:    cfg_bias = data & 32'h7FFFFFFF;
         REG_FRAC_SHIFT:  cfg_frac = data & 32'h1F;
         REG_MA_TAPS:     cfg_taps = data & 32'h1FF;
         REG_INTERP_LOG2: cfg_lg   = data & 32'h7;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic stim_row_type item_row(logic [31:0] mv, logic [1:0] sel, bit dn,
                                             bit typed = 0, logic [31:0] emv = 0,
                                             bit edn = 0);
      stim_row_type r;
      r = '{default: '0};
      r.move = mv; r.sel = sel; r.done = dn;
      r.typed = typed; r.exp_move = emv; r.exp_done = edn;
      return r;
   endfunction

   function automatic stim_row_type reg_row(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      stim_row_type r;
      r = '{default: '0};
      r.is_reg = 1'b1; r.idx = idx; r.data = data[CSR_DATA_W-1:0];
      return r;
   endfunction

   function automatic logic [31:0] pick_move();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return $urandom_range(65535) - 32'd32768;
         default: return $urandom_range(4000) - 32'd2000;
      endcase
   endfunction

   initial begin
      move_result_type tr, none;
      stim_row_type    row;
      logic [31:0]  taps, lg, gain, bias, frac;
      logic [1:0]   sel;
      int n, drain;

      none = '{move: 0, done: 0};
      error_count = 0; sent_count = 0; checked_count = 0; phase_count = 0;
      no_idle = 0;
      reset <= 1'b1;
      csr_we <= 1'b0; csr_index <= '0; csr_wdata <= '0;
      req_ch.valid <= 1'b0; req_ch.move_in <= '0;
      req_ch.filter_select <= MODE_NONE; req_ch.done_in <= 1'b0;
      cfg_gain = 0; cfg_bias = 0; cfg_frac = 0; cfg_taps = 0; cfg_lg = 0;
      act_mode = MODE_NONE; held_gain = 0; held_bias = 0; held_ma = 0;
      ma_adopted = 0;
      for (int i = 0; i < MA_DEPTH; i++) ring_mem[i] = 0;
      clear_filter_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // after reset every mode passes the increment through
      stim_table.push_back(item_row(32'h80000000, MODE_NONE, 1, 1, 32'h80000000, 1));
      stim_table.push_back(item_row(32'h7FFFFFFF, MODE_MA,   0, 1, 32'h7FFFFFFF, 0));
      stim_table.push_back(item_row(32'hFFFFFFFF, MODE_EXP,  1, 1, 32'hFFFFFFFF, 1));
      stim_table.push_back(item_row(32'h00000001, 2'd3,      1, 1, 32'h00000001, 1));
      stim_table.push_back(item_row(32'h00000000, MODE_MA,   1, 1, 32'h00000000, 1));
      stim_table.push_back(reg_row(REG_MA_TAPS, 3));
      stim_table.push_back(reg_row(REG_INTERP_LOG2, 0));
      stim_table.push_back(item_row(32'd1000, MODE_MA, 0));
      stim_table.push_back(item_row(-32'sd7, MODE_MA, 0));
      stim_table.push_back(item_row(32'h7FFFFFFF, MODE_MA, 0));
      stim_table.push_back(item_row(32'h80000000, MODE_MA, 0));
      for (int i = 0; i < 4; i++) stim_table.push_back(item_row(0, MODE_MA, 1));
      stim_table.push_back(reg_row(REG_MA_TAPS, 2));
      stim_table.push_back(reg_row(REG_INTERP_LOG2, 2));
      stim_table.push_back(item_row(32'd500, MODE_MA, 0));
      stim_table.push_back(item_row(0, MODE_MA, 1));
      // full gain, widest bias, shift beyond the fraction field
      stim_table.push_back(reg_row(REG_EXP_GAIN, 32'hFFFF));
      stim_table.push_back(reg_row(REG_EXP_BIAS, 32'h7FFFFFFF));
      stim_table.push_back(reg_row(REG_FRAC_SHIFT, 31));
      stim_table.push_back(item_row(32'h7FFFFFFF, MODE_EXP, 0));
      stim_table.push_back(item_row(32'h80000000, MODE_EXP, 0));
      stim_table.push_back(item_row(0, MODE_EXP, 1));
      stim_table.push_back(reg_row(REG_EXP_BIAS, 10));
      stim_table.push_back(reg_row(REG_FRAC_SHIFT, 16));
      stim_table.push_back(reg_row(REG_EXP_GAIN, 3));
      stim_table.push_back(item_row(32'd5, MODE_EXP, 0));
      stim_table.push_back(item_row(32'd100000, MODE_EXP, 0));
      stim_table.push_back(item_row(-32'sd100000, MODE_EXP, 0));
      stim_table.push_back(item_row(0, MODE_EXP, 1));
      stim_table.push_back(item_row(0, MODE_EXP, 1));
      // long average request saturates to the ring depth
      stim_table.push_back(reg_row(REG_MA_TAPS, 511));
      stim_table.push_back(reg_row(REG_INTERP_LOG2, 7));

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.is_reg) write_reg(row.idx, row.data);
         else begin
            tr = '{move: row.exp_move, done: row.exp_done};
            send_move(row.move, row.sel, row.done, row.typed, tr);
         end
      end

      // random phases: motion segments followed by a done drain
      while (sent_count < RANDOM_ITEMS) begin
         phase_count++;
         case ($urandom_range(3))
            0: gain = 0;
            1: gain = 32'hFFFF;
            default: gain = $urandom_range(1, 300);
         endcase
         case ($urandom_range(3))
            0: bias = 0;
            1: bias = 32'h7FFFFFFF;
            2: bias = $urandom & 32'h7FFFFFFF;
            default: bias = $urandom_range(5000);
         endcase
         frac = $urandom_range(9) == 0 ? $urandom_range(17, 31) : $urandom_range(16);
         case ($urandom_range(19))
            0: begin taps = 0; lg = $urandom_range(7); end
            1: begin taps = $urandom_range(1) ? 256 : 511; lg = 0; end
            2: begin taps = $urandom_range(1, 2); lg = 7; end
            default: begin taps = $urandom_range(1, 8); lg = $urandom_range(3); end
         endcase
         write_reg(REG_EXP_GAIN, gain);
         write_reg(REG_EXP_BIAS, bias);
         write_reg(REG_FRAC_SHIFT, frac);
         write_reg(REG_MA_TAPS, taps);
         write_reg(REG_INTERP_LOG2, lg);
         no_idle = (phase_count % 5 == 3);
         sel = $urandom_range(7) == 0 ? 2'($urandom_range(3)) :
                                        ($urandom_range(1) ? MODE_MA : MODE_EXP);
         for (int seg = 0; seg < 3 && sent_count < RANDOM_ITEMS; seg++) begin
            n = $urandom_range(4, 30);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(9) == 0)
                  send_move($urandom, 2'($urandom_range(3)), 1'($urandom_range(1)), 0, none);
               else
                  send_move(pick_move(), sel, 0, 0, none);
            end
            drain = 0;
            do begin
               send_move(0, sel, 1, 0, none);
               drain++;
            end while (!empty_flag && drain < 600 && sent_count < RANDOM_ITEMS);
         end
      end
      no_idle = 0;

      req_ch.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d increments over %0d random setting phases plus a directed table",
               sent_count, phase_count);
      $display("checked %0d filtered results, %0d mismatches", checked_count, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      move_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_moves.size() == 0) begin
            error_count++;
            $display("unexpected result transaction: move %h done %b",
                     rsp_ch.move_out, rsp_ch.done_out);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_ch.move_out !== want.move)
               report_mismatch("move_out", rsp_ch.move_out, want.move);
            if (rsp_ch.done_out !== want.done)
               report_mismatch("done_out", 32'(rsp_ch.done_out), 32'(want.done));
            checked_count++;
         end
      end
      rsp_ch.ready <= reset ? 1'b0 : (no_idle || $urandom_range(99) >= 36);
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
